### hdl/ssbc_pkg.sv
// Package for the scaled sprite blitter: store geometry, action codes, sequencer states.
// No dependencies.
`default_nettype none
package ssbc_pkg;
    localparam int SRC_WIDTH_DEF  = 4096;
    localparam int SRC_ROWS_DEF   = 256;
    localparam int DST_WIDTH_DEF  = 512;
    localparam int DST_HEIGHT_DEF = 256;

    typedef enum logic [2:0] {
        ACT_DRAW   = 3'd0,
        ACT_LOAD   = 3'd1,
        ACT_WRITE  = 3'd2,
        ACT_RD_SRC = 3'd3,
        ACT_RD_DST = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        CFG_MIN_X = 2'd0,
        CFG_MIN_Y = 2'd1,
        CFG_MAX_X = 2'd2,
        CFG_MAX_Y = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIPX,
        ST_CLIPY,
        ST_MULX,
        ST_MULY,
        ST_SETUP,
        ST_FILLRD,
        ST_FILLWT,
        ST_FILL,
        ST_PXRD,
        ST_PXWT,
        ST_PXWR,
        ST_RDWT,
        ST_RDOUT,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

### hdl/scaled_sprite_blitter_with_clip_core.sv
// Scaled sprite blitter: a draw runs clip, multiply, setup, then a scaled loop (read, wait, write
// per pixel), an opaque fill (one source read, a write per pixel) or, if clipped away, nothing;
// loads, writes and unused actions go straight to the result, which is held while m_axis_tready
// is low. One item at a time: the next is taken in the cycle after the result transfer; the pixel
// loop is bound by the registered source read. Synchronous active-low reset sets control and clip
// regs (min 0, max 511/255); stores undefined until written, no clearing pass. Uses ssbc_pkg.
`default_nettype none
module scaled_sprite_blitter_with_clip_core #(
    parameter int SRC_WIDTH  = ssbc_pkg::SRC_WIDTH_DEF,
    parameter int SRC_ROWS   = ssbc_pkg::SRC_ROWS_DEF,
    parameter int DST_WIDTH  = ssbc_pkg::DST_WIDTH_DEF,
    parameter int DST_HEIGHT = ssbc_pkg::DST_HEIGHT_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // action[2:0], src_x[30:3], src_y[54:31], x_step[86:55], y_step[118:87],
    // width_code[127:119], height_code[136:128], dst_x[148:137], dst_y[160:149],
    // mask_bits[168:161], color_bits[176:169], pixel_value[184:177]
    input  wire logic [191:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // read_value[7:0]
    output logic [7:0]        m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [11:0]  i_cfg_data
);
    import ssbc_pkg::*;

    localparam int SXW = $clog2(SRC_WIDTH);
    localparam int SYW = $clog2(SRC_ROWS);
    localparam int SAW = SXW + SYW;
    localparam int DXW = $clog2(DST_WIDTH);
    localparam int DYW = $clog2(DST_HEIGHT);
    localparam int DAW = DXW + DYW;
    localparam int DSIZE = DST_WIDTH * DST_HEIGHT;

    logic [7:0] r_src_mem [SRC_WIDTH*SRC_ROWS];
    logic [7:0] r_dst_mem [DSIZE];

    t_state r_state, n_state;
    logic [11:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic [2:0]  r_act;
    logic [31:0] r_sx, r_sy, r_xs, r_ys, r_cx, r_cy;
    logic signed [13:0] r_w, r_h, r_dx, r_dy, r_ix, r_iy;
    logic [11:0] r_lx, r_ly;
    logic [7:0]  r_keep, r_color, r_pix, r_out, r_rd;
    logic [11:0] r_ddx, r_ddy;
    logic [SAW-1:0] r_src_addr;
    logic [DAW-1:0] r_dst_addr;
    logic        r_dst_we, r_src_we;
    logic [7:0]  r_wdata;
    logic [DAW-1:0] r_rd_addr;
    logic [31:0] r_mul_a;
    logic [11:0] r_mul_b;
    logic [31:0] r_prod;

    logic [191:0] d;
    assign d = s_axis_tdata;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_out;

    function automatic logic [SAW-1:0] src_idx(input logic [31:0] x, input logic [31:0] y);
        src_idx = {y[16 +: SYW], x[16 +: SXW]};
    endfunction

    // destination address of a pixel, with in-range flag
    logic signed [24:0] pa;
    logic               pa_ok;
    always_comb begin
        pa = 25'(r_dy + r_iy) * 25'(DST_WIDTH) + 25'(r_dx + r_ix);
        pa_ok = (pa >= 0) && (pa < 25'(DSIZE));
    end

    logic signed [13:0] mx, my, mnx, mny;
    assign mx = 14'(r_max_x);
    assign my = 14'(r_max_y);
    assign mnx = 14'(r_min_x);
    assign mny = 14'(r_min_y);

    logic dvalid;
    assign dvalid = (r_ddx < 12'(DST_WIDTH)) && (r_ddy < 12'(DST_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_min_x <= '0;
            r_min_y <= '0;
            r_max_x <= 12'd511;
            r_max_y <= 12'd255;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MIN_X: r_min_x <= i_cfg_data;
                    CFG_MIN_Y: r_min_y <= i_cfg_data;
                    CFG_MAX_X: r_max_x <= i_cfg_data;
                    CFG_MAX_Y: r_max_y <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (r_src_we) r_src_mem[r_src_addr] <= r_wdata;
        r_pix <= r_src_mem[r_src_addr];
        if (r_dst_we) r_dst_mem[r_dst_addr] <= r_wdata;
        r_rd <= r_dst_mem[r_rd_addr];
    end

    // shared multiplier: one 32x12 product, registered
    always_ff @(posedge i_clk) r_prod <= r_mul_a * 32'(r_mul_b);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_axis_tvalid) begin
                case (t_action'(d[2:0]))
                    ACT_DRAW:   n_state = ST_CLIPX;
                    ACT_LOAD:   n_state = ST_OUT;
                    ACT_WRITE:  n_state = ST_OUT;
                    ACT_RD_SRC: n_state = ST_RDWT;
                    ACT_RD_DST: n_state = ST_RDWT;
                    default:    n_state = ST_OUT;
                endcase
            end
            ST_CLIPX:  n_state = ST_CLIPY;
            ST_CLIPY:  n_state = ST_MULX;
            ST_MULX:   n_state = ST_MULY;
            ST_MULY:   n_state = ST_SETUP;
            ST_SETUP:  n_state = (r_w <= 0 || r_h <= 0) ? ST_OUT :
                                 (r_xs == 0 && r_ys == 0) ? ST_FILLRD : ST_PXRD;
            ST_FILLRD: n_state = ST_FILLWT;
            ST_FILLWT: n_state = ST_FILL;
            ST_FILL:   if (r_ix == r_w - 1 && r_iy == r_h - 1) n_state = ST_OUT;
            ST_PXRD:   n_state = ST_PXWT;
            ST_PXWT:   n_state = ST_PXWR;
            ST_PXWR:   n_state = (r_ix == r_w - 1 && r_iy == r_h - 1) ? ST_OUT : ST_PXRD;
            ST_RDWT:   n_state = ST_RDOUT;
            ST_RDOUT:  n_state = ST_OUT;
            ST_OUT:    if (m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_src_we <= 1'b0;
        r_dst_we <= 1'b0;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) begin
                r_act   <= d[2:0];
                r_sx    <= {4'd0, d[30:3]};
                r_sy    <= {8'd0, d[54:31]};
                r_xs    <= d[86:55];
                r_ys    <= d[118:87];
                r_w     <= 14'(d[127:119]) + 14'sd1;
                r_h     <= 14'(d[136:128]) + 14'sd1;
                r_dx    <= 14'(d[145:137]);
                r_dy    <= 14'(d[157:149]);
                r_ddx   <= d[148:137];
                r_ddy   <= d[160:149];
                r_keep  <= ~d[168:161];
                r_color <= d[176:169] & d[168:161];
                r_wdata <= d[184:177];
                r_out   <= '0;
                r_src_addr <= src_idx({4'd0, d[30:3]}, {8'd0, d[54:31]});
                r_rd_addr  <= DAW'(d[160:149]) * DAW'(DST_WIDTH) + DAW'(d[148:137]);
                r_dst_addr <= DAW'(d[160:149]) * DAW'(DST_WIDTH) + DAW'(d[148:137]);
                if (t_action'(d[2:0]) == ACT_LOAD) r_src_we <= 1'b1;
                if (t_action'(d[2:0]) == ACT_WRITE &&
                    d[148:137] < 12'(DST_WIDTH) && d[160:149] < 12'(DST_HEIGHT))
                    r_dst_we <= 1'b1;
            end
            ST_CLIPX: begin
                // right wrap, then left clip amount
                if (r_dx > mx) begin
                    r_w  <= r_w - (14'sd512 - r_dx);
                    r_dx <= '0;
                    r_lx <= (mnx > 0) ? 12'(mnx) : '0;
                end else begin
                    r_lx <= (r_dx < mnx) ? 12'(mnx - r_dx) : '0;
                end
                r_ly <= (r_dy < mny) ? 12'(mny - r_dy) : '0;
            end
            ST_CLIPY: begin
                r_w  <= r_w - 14'(r_lx);
                r_dx <= r_dx + 14'(r_lx);
                r_h  <= r_h - 14'(r_ly);
                r_dy <= r_dy + 14'(r_ly);
                r_mul_a <= r_xs;
                r_mul_b <= r_lx;
            end
            ST_MULX: begin
                if (r_dx + r_w > mx) r_w <= mx - r_dx + 14'sd1;
                if (r_dy + r_h > my) r_h <= my - r_dy + 14'sd1;
                r_mul_a <= r_ys;
                r_mul_b <= r_ly;
            end
            ST_MULY: r_sx <= r_sx + r_prod;
            ST_SETUP: begin
                r_sy <= r_sy + r_prod;
                r_cx <= r_sx;
                r_cy <= r_sy + r_prod;
                r_ix <= '0;
                r_iy <= '0;
                r_src_addr <= src_idx(r_sx, r_sy + r_prod);
            end
            ST_FILLWT: r_wdata <= r_color | (r_pix & r_keep);
            ST_FILL: begin
                r_dst_addr <= pa[DAW-1:0];
                r_dst_we   <= pa_ok;
                if (r_ix == r_w - 1) begin
                    r_ix <= '0;
                    r_iy <= r_iy + 14'sd1;
                end else r_ix <= r_ix + 14'sd1;
            end
            ST_PXRD: r_src_addr <= src_idx(r_cx, r_cy);
            ST_PXWR: begin
                r_wdata    <= r_color | (r_pix & r_keep);
                r_dst_addr <= pa[DAW-1:0];
                r_dst_we   <= pa_ok && (r_pix != 8'd0);
                if (r_ix == r_w - 1) begin
                    r_ix <= '0;
                    r_iy <= r_iy + 14'sd1;
                    r_cx <= r_sx;
                    r_cy <= r_cy + r_ys;
                end else begin
                    r_ix <= r_ix + 14'sd1;
                    r_cx <= r_cx + r_xs;
                end
            end
            ST_RDOUT: begin
                if (t_action'(r_act) == ACT_RD_SRC) r_out <= r_pix;
                else r_out <= dvalid ? r_rd : 8'd0;
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("result while accepting");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_no_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && $past(r_state) == ST_OUT) |-> !r_dst_we)
        else $error("stray write");
`endif
endmodule
`default_nettype wire

### tb/scaled_sprite_blitter_with_clip_core_tb.sv
// Self-checking testbench for scaled_sprite_blitter_with_clip_core: a directed table,
// then random item streams under several clip settings, all scored by a built-in blitter model.
// Depends on ssbc_pkg and the core RTL.
module scaled_sprite_blitter_with_clip_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssbc_pkg::*;

    localparam int          DST_PIXELS   = DST_WIDTH_DEF * DST_HEIGHT_DEF;
    localparam int          CYCLE_LIMIT  = 4_000_000;
    localparam logic [2:0]  ACT_UNUSED_5 = 3'd5;
    localparam logic [2:0]  ACT_UNUSED_6 = 3'd6;
    localparam logic [2:0]  ACT_UNUSED_7 = 3'd7;

    typedef struct {
        bit [2:0]  act;
        bit [27:0] sx;
        bit [23:0] sy;
        bit [31:0] xs;
        bit [31:0] ys;
        bit [8:0]  wc;
        bit [8:0]  hc;
        bit [11:0] dx;
        bit [11:0] dy;
        bit [7:0]  mk;
        bit [7:0]  cl;
        bit [7:0]  px;
    } blit_item_t;

    typedef struct {
        blit_item_t it;
        bit         typed;
        bit [7:0]   rv;
    } blit_row_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [11:0]  i_cfg_data = '0;

    scaled_sprite_blitter_with_clip_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // blitter state mirror: only written entries exist
    bit [7:0]    src_mem [int unsigned];
    bit [7:0]    dst_mem [int];
    int unsigned src_keys[$];
    bit [11:0]   clip_reg[4];
    bit [7:0]    read_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int n_items = 0;
    int n_draws = 0;
    int n_checked = 0;
    int cycles = 0;

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned src_addr(bit [31:0] x, bit [31:0] y);
        return ((y >> 16) & (SRC_ROWS_DEF - 1)) * SRC_WIDTH_DEF + ((x >> 16) % SRC_WIDTH_DEF);
    endfunction

    function automatic void dst_put(int row, int col, bit [7:0] v);
        int a;
        a = row * DST_WIDTH_DEF + col;
        if (a >= 0 && a < DST_PIXELS) dst_mem[a] = v;
    endfunction

    // walk a draw: with commit clear, only list source pixels not yet written
    function automatic void blit_walk(blit_item_t it, bit commit, ref int unsigned need[$]);
        bit [31:0]   sx, sy, cx, cy;
        int          w, h, dx, dy, minx, miny, maxx, maxy;
        bit [7:0]    keep, color, p;
        int unsigned a;
        sx = it.sx;
        sy = it.sy;
        w = int'(it.wc) + 1;
        h = int'(it.hc) + 1;
        dx = int'(it.dx[8:0]);
        dy = int'(it.dy[8:0]);
        keep = ~it.mk;
        color = it.cl & it.mk;
        minx = clip_reg[CFG_MIN_X];
        miny = clip_reg[CFG_MIN_Y];
        maxx = clip_reg[CFG_MAX_X];
        maxy = clip_reg[CFG_MAX_Y];
        if (dx > maxx) begin
            w -= 512 - dx;
            dx = 0;
        end
        if (dx < minx) begin
            sx += it.xs * 32'(minx - dx);
            w -= minx - dx;
            dx = minx;
        end
        if (dx + w > maxx) w = maxx - dx + 1;
        if (dy < miny) begin
            sy += it.ys * 32'(miny - dy);
            h -= miny - dy;
            dy = miny;
        end
        if (dy + h > maxy) h = maxy - dy + 1;
        if (it.xs == 0 && it.ys == 0) begin
            a = src_addr(sx, sy);
            if (!commit) begin
                if (!src_mem.exists(a)) need.push_back(a);
            end else begin
                p = color | (src_mem[a] & keep);
                if (w > 0)
                    for (int y = 0; y < h; y++)
                        for (int x = 0; x < w; x++) dst_put(dy + y, dx + x, p);
            end
        end else begin
            cy = sy;
            for (int y = 0; y < h; y++) begin
                cx = sx;
                for (int x = 0; x < w; x++) begin
                    a = src_addr(cx, cy);
                    if (!commit) begin
                        if (!src_mem.exists(a)) need.push_back(a);
                    end else begin
                        p = src_mem[a];
                        if (p != 0) dst_put(dy + y, dx + x, color | (p & keep));
                    end
                    cx += it.xs;
                end
                cy += it.ys;
            end
        end
    endfunction

    function automatic bit [7:0] blit_apply(blit_item_t it);
        int unsigned none[$];
        int unsigned a;
        bit          in_range;
        int          da;
        a = src_addr(it.sx, it.sy);
        in_range = it.dx < DST_WIDTH_DEF && it.dy < DST_HEIGHT_DEF;
        da = int'(it.dy) * DST_WIDTH_DEF + int'(it.dx);
        case (it.act)
            ACT_DRAW: blit_walk(it, 1'b1, none);
            ACT_LOAD: begin
                if (!src_mem.exists(a)) src_keys.push_back(a);
                src_mem[a] = it.px;
            end
            ACT_WRITE: if (in_range) dst_mem[da] = it.px;
            ACT_RD_SRC: return src_mem.exists(a) ? src_mem[a] : 8'h00;
            ACT_RD_DST: if (in_range && dst_mem.exists(da)) return dst_mem[da];
            default: ;
        endcase
        return 8'h00;
    endfunction

    function automatic blit_item_t item_of(bit [2:0] act, bit [27:0] sx, bit [23:0] sy,
                                           bit [31:0] xs, bit [31:0] ys, bit [8:0] wc,
                                           bit [8:0] hc, bit [11:0] dx, bit [11:0] dy,
                                           bit [7:0] mk, bit [7:0] cl, bit [7:0] px);
        return '{act, sx, sy, xs, ys, wc, hc, dx, dy, mk, cl, px};
    endfunction

    task automatic send_raw(blit_item_t it, bit typed, bit [7:0] rv);
        bit [7:0] pred;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, it.px, it.cl, it.mk, it.dy, it.dx, it.hc, it.wc,
                         it.ys, it.xs, it.sy, it.sx, it.act};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = blit_apply(it);
        read_q.push_back(typed ? rv : pred);
        n_items++;
    endtask

    // load any source pixel a draw would read that was never written, then transfer the item
    task automatic send_item(blit_item_t it, bit typed = 1'b0, bit [7:0] rv = 8'h00);
        int unsigned need[$];
        bit [7:0]    v;
        if (it.act == ACT_DRAW) begin
            blit_walk(it, 1'b0, need);
            foreach (need[i]) begin
                if (src_mem.exists(need[i])) continue;
                v = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
                send_raw(item_of(ACT_LOAD, {12'(need[i] % SRC_WIDTH_DEF), 16'($urandom)},
                                 {8'(need[i] / SRC_WIDTH_DEF), 16'($urandom)},
                                 $urandom, $urandom, 9'($urandom), 9'($urandom),
                                 12'($urandom), 12'($urandom), 8'($urandom),
                                 8'($urandom), v), 1'b0, 8'h00);
            end
            n_draws++;
        end
        send_raw(it, typed, rv);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (read_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic clip_set(bit [11:0] min_x, bit [11:0] min_y, bit [11:0] max_x,
                            bit [11:0] max_y);
        bit [11:0] vals[4];
        vals = '{min_x, min_y, max_x, max_y};
        i_cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++) begin
            i_cfg_index <= t_cfg_idx'(i);
            i_cfg_data <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            clip_reg[i] = vals[i];
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic blit_item_t random_item();
        blit_item_t it;
        int         pick;
        bit         fill;
        int unsigned a;
        it = item_of(ACT_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom);
        pick = $urandom_range(99);
        if (pick < 40) begin
            fill = $urandom_range(3) == 0;
            if (fill) begin
                it.xs = 0;
                it.ys = 0;
            end else begin
                if ($urandom_range(1)) it.xs = $urandom_range(0, 32'h30000);
                if ($urandom_range(1)) it.ys = $urandom_range(0, 32'h30000);
            end
            // larger sizes only for fills, where one source pixel is read
            if (fill && $urandom_range(24) == 0) begin
                it.wc = $urandom_range(0, 63);
                it.hc = $urandom_range(0, 63);
            end else begin
                it.wc = $urandom_range(0, 2);
                it.hc = $urandom_range(0, 2);
            end
        end else if (pick < 60) begin
            it.act = ACT_LOAD;
        end else if (pick < 75) begin
            it.act = ACT_WRITE;
            if ($urandom_range(3) != 0) begin
                it.dx = $urandom_range(0, DST_WIDTH_DEF - 1);
                it.dy = $urandom_range(0, DST_HEIGHT_DEF - 1);
            end
        end else if (pick < 85) begin
            it.act = ACT_RD_SRC;
            a = src_keys[$urandom_range(0, src_keys.size() - 1)];
            it.sx = {12'(a % SRC_WIDTH_DEF), 16'($urandom)};
            it.sy = {8'(a / SRC_WIDTH_DEF), 16'($urandom)};
        end else if (pick < 95) begin
            it.act = ACT_RD_DST;
            if ($urandom_range(3) != 0) begin
                it.dx = $urandom_range(0, DST_WIDTH_DEF - 1);
                it.dy = $urandom_range(0, DST_HEIGHT_DEF - 1);
            end
        end else begin
            it.act = 3'($urandom_range(ACT_UNUSED_5, ACT_UNUSED_7));
        end
        return it;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (read_q.size() == 0) begin
                $display("%0t: read_value transfer with none expected: expected none, got %02h",
                         $time, m_axis_tdata);
                errors++;
            end else begin
                if (m_axis_tdata !== read_q[0]) begin
                    $display("%0t: read_value mismatch: expected %02h, got %02h",
                             $time, read_q[0], m_axis_tdata);
                    errors++;
                end
                void'(read_q.pop_front());
                n_checked++;
            end
        end
        m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    initial begin
        blit_row_t   rows[$];
        bit [11:0]   clips[6][4];
        clip_reg = '{12'd0, 12'd0, 12'd511, 12'd255};
        rows.push_back('{item_of(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'h5a), 0, 0});
        rows.push_back('{item_of(ACT_RD_SRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 8'h5a});
        rows.push_back('{item_of(ACT_LOAD, 28'hfffffff, 24'hffffff, 0, 0, 0, 0, 0, 0,
                                 0, 0, 8'hff), 0, 0});
        rows.push_back('{item_of(ACT_RD_SRC, 28'hfffffff, 24'hffffff, 0, 0, 0, 0, 0, 0,
                                 0, 0, 0), 1, 8'hff});
        rows.push_back('{item_of(ACT_LOAD, 28'h10000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{item_of(ACT_WRITE, 0, 0, 0, 0, 0, 0, 511, 255, 0, 0, 8'ha5), 0, 0});
        rows.push_back('{item_of(ACT_RD_DST, 0, 0, 0, 0, 0, 0, 511, 255, 0, 0, 0), 1, 8'ha5});
        rows.push_back('{item_of(ACT_WRITE, 0, 0, 0, 0, 0, 0, 12'hfff, 12'hfff, 0, 0, 8'h11),
                         0, 0});
        rows.push_back('{item_of(ACT_RD_DST, 0, 0, 0, 0, 0, 0, 512, 0, 0, 0, 0), 1, 8'h00});
        rows.push_back('{item_of(ACT_RD_DST, 0, 0, 0, 0, 0, 0, 0, 256, 0, 0, 0), 1, 8'h00});
        rows.push_back('{item_of(ACT_RD_DST, 0, 0, 0, 0, 0, 0, 12'hfff, 12'hfff, 0, 0, 0),
                         1, 8'h00});
        rows.push_back('{item_of(ACT_UNUSED_5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hff), 1, 8'h00});
        rows.push_back('{item_of(ACT_UNUSED_6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hff), 1, 8'h00});
        rows.push_back('{item_of(ACT_UNUSED_7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hff), 1, 8'h00});
        // opaque fill of the whole store
        rows.push_back('{item_of(ACT_DRAW, 0, 0, 0, 0, 9'h1ff, 9'h1ff, 0, 0, 8'hf0, 8'hff, 0),
                         1, 8'h00});
        rows.push_back('{item_of(ACT_RD_DST, 0, 0, 0, 0, 0, 0, 100, 100, 0, 0, 0), 1, 8'hfa});
        // fill from a zero source pixel writes zeros
        rows.push_back('{item_of(ACT_DRAW, 28'h10000, 0, 0, 0, 2, 2, 10, 10, 8'h00, 8'hff, 0),
                         1, 8'h00});
        rows.push_back('{item_of(ACT_RD_DST, 0, 0, 0, 0, 0, 0, 11, 11, 0, 0, 0), 1, 8'h00});
        // scaled draw clipped at the bottom-right corner
        rows.push_back('{item_of(ACT_DRAW, 0, 0, 32'h10000, 32'h10000, 9'h1ff, 9'h1ff,
                                 508, 253, 8'h0f, 8'haa, 0), 1, 8'h00});
        rows.push_back('{item_of(ACT_RD_DST, 0, 0, 0, 0, 0, 0, 509, 254, 0, 0, 0), 0, 0});
        rows.push_back('{item_of(ACT_DRAW, 28'h123_4567, 24'h65_4321, 32'hffffffff,
                                 32'hffffffff, 3, 3, 12'hfff, 12'hfff, 8'hff, 8'hff, 0),
                         0, 0});

        clips = '{'{12'd0, 12'd0, 12'd511, 12'd255},
                  '{12'd5, 12'd3, 12'd40, 12'd30},
                  '{12'd200, 12'd100, 12'd300, 12'd200},
                  '{12'd100, 12'd50, 12'd90, 12'd20},
                  '{12'd0, 12'd0, 12'd4095, 12'd4095},
                  '{12'd4095, 12'd4095, 12'd0, 12'd0}};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 13;
        recv_stall_pct = 82;
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].rv);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 82 : 0;
            recv_stall_pct = (ph < 2) ? 82 : (ph < 4) ? 13 : 0;
            clip_set(clips[ph][0], clips[ph][1], clips[ph][2], clips[ph][3]);
            for (int n = 0; n < 12; n++) begin
                // hold off until every read_value has come back
                if (n == 6) begin
                    s_axis_tvalid <= 1'b0;
                    while (read_q.size() != 0) @(posedge i_clk);
                end
                send_item(random_item());
            end
            drain();
        end

        $display("Transferred %0d items (%0d draws), checked %0d results", n_items, n_draws,
                 n_checked);
        $display("Covered six clip settings incl. full-range, inverted and wrap-around");
        if (errors == 0 && read_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results still expected", errors, read_q.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
